### src/psw_pkg.sv
// Package for the page framebuffer span writer: sizes, types and address helper.
package psw_pkg;

  localparam int SCREEN_COLUMNS = 128;
  localparam int SCREEN_PAGES = 8;
  localparam int MAX_SPAN_PAGES = 8;
  localparam int SCREEN_ROWS = SCREEN_PAGES * 8;
  localparam int STORE_DEPTH = SCREEN_PAGES * SCREEN_COLUMNS;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int PAGE_W = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [PAGE_W-1:0] page_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic       en;
    addr_t      addr;
    logic [7:0] data;
  } ram_wr_t;

  function automatic addr_t frame_addr(page_t page, logic [7:0] col);
    frame_addr = ADDR_W'(int'(page) * SCREEN_COLUMNS + int'(col));
  endfunction

endpackage

### src/page_framebuffer_span_writer_unit.sv
// Top level: span decode, page sequencer, read-modify-write of the frame store.
//
//  channel | direction | handshake            | fields
//  in      | input     | in_valid_i/in_stall_o   | column_x, row_first, row_second, ink
//  out     | output    | out_valid_o/out_stall_i | half_sel, page_index, column_in_half,
//          |           |                         | byte_value, last_write
//
// After reset a clearing pass writes zero to all 1024 store entries, one per cycle;
// the input is stalled until the clearing pass is done.
// A span is accepted, then one page (1 to 8 pages) is written per cycle while the output
// is not stalled, a pace set by the single read and single write port of the frame store;
// an empty or off-screen word is accepted and writes nothing.
// The next word is accepted in the cycle after the last byte is written.
// An output stall holds the sequencer on the current page.
module page_framebuffer_span_writer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] column_x_i,
  input  logic [7:0] row_first_i,
  input  logic [7:0] row_second_i,
  input  logic       ink_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       half_sel_o,
  output logic [2:0] page_index_o,
  output logic [5:0] column_in_half_o,
  output logic [7:0] byte_value_o,
  output logic       last_write_o
);

  psw_pkg::state_e state_q, state_d;
  psw_pkg::addr_t  clr_q, clr_d;
  psw_pkg::ram_wr_t wr;
  psw_pkg::addr_t  rd_addr;
  logic [7:0]      rd_data;

  logic [7:0]      col_q;
  logic [2:0]      lo3_q, hi3_q;
  psw_pkg::page_t  first_q, end_q, stop_q, page_q;
  logic            ink_q;

  logic            out_valid_q;
  logic            half_q, last_q;
  logic [2:0]      page_out_q;
  logic [5:0]      colh_q;
  logic [7:0]      byte_q;

  // span decode
  logic [7:0]      lo, hi, hi_c, lo_sh, hi_sh;
  psw_pkg::page_t  first_in, end_in, stop_in;
  logic            span_ok;

  always_comb begin
    lo = (row_first_i > row_second_i) ? row_second_i : row_first_i;
    hi = (row_first_i > row_second_i) ? row_first_i : row_second_i;
    hi_c = (int'(hi) > psw_pkg::SCREEN_ROWS - 1) ? 8'(psw_pkg::SCREEN_ROWS - 1) : hi;
    span_ok = (int'(column_x_i) < psw_pkg::SCREEN_COLUMNS) &&
              (int'(lo) < psw_pkg::SCREEN_ROWS);
    lo_sh = lo >> 3;
    hi_sh = hi_c >> 3;
    first_in = lo_sh[psw_pkg::PAGE_W-1:0];
    end_in = hi_sh[psw_pkg::PAGE_W-1:0];
    stop_in = end_in;
    if (int'(end_in) - int'(first_in) > psw_pkg::MAX_SPAN_PAGES - 1) begin
      stop_in = psw_pkg::PAGE_W'(int'(first_in) + psw_pkg::MAX_SPAN_PAGES - 1);
    end
  end

  // page modify
  logic           out_free, last_pg, accept;
  logic [7:0]     keep, new_byte, page8;
  psw_pkg::page_t rd_page;

  assign out_free = !out_valid_q || !out_stall_i;
  assign last_pg = (page_q == stop_q);
  assign accept = in_valid_i && !in_stall_o;
  assign page8 = 8'(page_q);

  always_comb begin
    keep = 8'h00;
    if (page_q == first_q) begin
      keep = keep | ((8'd1 << lo3_q) - 8'd1);
    end
    if (page_q == end_q) begin
      keep = keep | (8'hfe << hi3_q);
    end
    new_byte = ink_q ? (rd_data | ~keep) : (rd_data & keep);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      psw_pkg::ST_CLEAR: begin
        if (clr_q == psw_pkg::ADDR_W'(psw_pkg::STORE_DEPTH - 1)) begin
          state_d = psw_pkg::ST_IDLE;
        end
      end
      psw_pkg::ST_IDLE: begin
        if (in_valid_i && span_ok) begin
          state_d = psw_pkg::ST_WRITE;
        end
      end
      psw_pkg::ST_WRITE: begin
        if (out_free && last_pg) begin
          state_d = psw_pkg::ST_IDLE;
        end
      end
      default: state_d = psw_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    wr = '0;
    rd_page = page_q;
    clr_d = clr_q;
    case (state_q)
      psw_pkg::ST_CLEAR: begin
        wr.en = 1'b1;
        wr.addr = clr_q;
        wr.data = 8'h00;
        clr_d = clr_q + psw_pkg::ADDR_W'(1);
      end
      psw_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        rd_page = first_in;
      end
      psw_pkg::ST_WRITE: begin
        if (out_free) begin
          wr.en = 1'b1;
          wr.addr = psw_pkg::frame_addr(page_q, col_q);
          wr.data = new_byte;
          if (!last_pg) begin
            rd_page = page_q + psw_pkg::PAGE_W'(1);
          end
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
    rd_addr = psw_pkg::frame_addr(rd_page,
                                  (state_q == psw_pkg::ST_IDLE) ? column_x_i : col_q);
  end

  psw_frame_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psw_pkg::ST_CLEAR;
      clr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      if (state_q == psw_pkg::ST_WRITE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q <= column_x_i;
      lo3_q <= lo[2:0];
      hi3_q <= hi_c[2:0];
      first_q <= first_in;
      end_q <= end_in;
      stop_q <= stop_in;
      page_q <= first_in;
      ink_q <= ink_i;
    end else if (state_q == psw_pkg::ST_WRITE && out_free && !last_pg) begin
      page_q <= page_q + psw_pkg::PAGE_W'(1);
    end
    if (state_q == psw_pkg::ST_WRITE && out_free) begin
      half_q <= col_q[6];
      page_out_q <= page8[2:0];
      colh_q <= col_q[5:0];
      byte_q <= new_byte;
      last_q <= last_pg;
    end
  end

  assign out_valid_o = out_valid_q;
  assign half_sel_o = half_q;
  assign page_index_o = page_out_q;
  assign column_in_half_o = colh_q;
  assign byte_value_o = byte_q;
  assign last_write_o = last_q;

endmodule

### src/psw_frame_ram.sv
// Frame store: one write port, one registered read port.
module psw_frame_ram (
  input  logic             clk_i,
  input  psw_pkg::ram_wr_t wr_i,
  input  psw_pkg::addr_t   rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0] mem [psw_pkg::STORE_DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/psw_checker.sv
// Port-level checks for the span writer, bound to the top level.
module psw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] column_x_i,
  input logic [7:0] row_first_i,
  input logic [7:0] row_second_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] byte_value_o,
  input logic       last_write_o
);

  logic in_acc;
  logic on_screen;

  assign in_acc = in_valid_i && !in_stall_o;
  assign on_screen = (int'(column_x_i) < psw_pkg::SCREEN_COLUMNS) &&
                     ((int'(row_first_i) < psw_pkg::SCREEN_ROWS) ||
                      (int'(row_second_i) < psw_pkg::SCREEN_ROWS));

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(byte_value_o) &&
                                   $stable(last_write_o))
    else $error("stalled output word changed");

  a_busy_after_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && on_screen |=> in_stall_o)
    else $error("span accepted but block not busy");

  a_idle_after_noop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !on_screen |=> !in_stall_o)
    else $error("off-screen word left block busy");

  // a non-last word on the output means the span still has pages to write
  a_busy_mid_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_write_o |-> in_stall_o)
    else $error("input taken before span finished");

endmodule

bind page_framebuffer_span_writer_unit psw_checker u_psw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .column_x_i   (column_x_i),
  .row_first_i  (row_first_i),
  .row_second_i (row_second_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .byte_value_o (byte_value_o),
  .last_write_o (last_write_o)
);

### tb/tb_page_framebuffer_span_writer_unit.sv
// Testbench for page_framebuffer_span_writer_unit: spans, shadow frame predictor, byte check.
module tb_page_framebuffer_span_writer_unit;

  localparam int IDLE_LIMIT = 4000;
  localparam int MAX_WAIT = 6;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic       half;
    logic [2:0] page;
    logic [5:0] col;
    logic [7:0] value;
    logic       last;
  } page_write_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] column_x_i = 8'h00;
  logic [7:0] row_first_i = 8'h00;
  logic [7:0] row_second_i = 8'h00;
  logic       ink_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       half_sel_o;
  logic [2:0] page_index_o;
  logic [5:0] column_in_half_o;
  logic [7:0] byte_value_o;
  logic       last_write_o;

  page_framebuffer_span_writer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .column_x_i      (column_x_i),
    .row_first_i     (row_first_i),
    .row_second_i    (row_second_i),
    .ink_i           (ink_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .half_sel_o      (half_sel_o),
    .page_index_o    (page_index_o),
    .column_in_half_o(column_in_half_o),
    .byte_value_o    (byte_value_o),
    .last_write_o    (last_write_o)
  );

  logic [7:0]  shadow_frame [psw_pkg::STORE_DEPTH];
  page_write_t pending_writes [$];
  int          err_count = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Read-modify-write of every page byte the span touches, top page first.
  function automatic void draw_span(logic [7:0] col, logic [7:0] r_a, logic [7:0] r_b,
                                    logic ink);
    int          lo, hi, first_pg, end_pg, stop_pg, pg, addr;
    logic [7:0]  keep, old, upd;
    page_write_t w;
    lo = int'(r_a);
    hi = int'(r_b);
    if (lo > hi) begin
      lo = int'(r_b);
      hi = int'(r_a);
    end
    if (col >= psw_pkg::SCREEN_COLUMNS || lo >= psw_pkg::SCREEN_ROWS) return;
    if (hi > psw_pkg::SCREEN_ROWS - 1) hi = psw_pkg::SCREEN_ROWS - 1;
    first_pg = lo / 8;
    end_pg = hi / 8;
    stop_pg = end_pg;
    if (stop_pg - first_pg > psw_pkg::MAX_SPAN_PAGES - 1)
      stop_pg = first_pg + psw_pkg::MAX_SPAN_PAGES - 1;
    for (pg = first_pg; pg <= stop_pg; pg++) begin
      keep = 8'h00;
      if (pg == first_pg) keep = keep | 8'((16'd1 << (lo % 8)) - 16'd1);
      if (pg == end_pg) keep = keep | 8'(16'h00fe << (hi % 8));
      addr = pg * psw_pkg::SCREEN_COLUMNS + int'(col);
      if (addr >= psw_pkg::STORE_DEPTH) break;
      old = shadow_frame[psw_pkg::ADDR_W'(addr)];
      upd = ink ? (old | ~keep) : (old & keep);
      shadow_frame[psw_pkg::ADDR_W'(addr)] = upd;
      w.half = col[6];
      w.page = 3'(pg);
      w.col = col[5:0];
      w.value = upd;
      w.last = (pg == stop_pg);
      pending_writes.push_back(w);
    end
  endfunction

  task automatic send_word(input logic [7:0] col, input logic [7:0] r_a,
                           input logic [7:0] r_b, input logic ink);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    column_x_i <= col;
    row_first_i <= r_a;
    row_second_i <= r_b;
    ink_i <= ink;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    draw_span(col, r_a, r_b, ink);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_writes.size() != 0);
  endtask

  task automatic test_directed();
    send_word(8'd0, 8'd0, 8'd63, 1'b1);
    send_word(8'd127, 8'd63, 8'd0, 1'b1);
    send_word(8'd0, 8'd0, 8'd0, 1'b0);
    send_word(8'd64, 8'd63, 8'd63, 1'b1);
    send_word(8'd63, 8'd5, 8'd5, 1'b1);
    send_word(8'd127, 8'd9, 8'd62, 1'b0);
    send_word(8'd10, 8'd40, 8'd3, 1'b1);
    send_word(8'd10, 8'd17, 8'd22, 1'b0);
    send_word(8'd128, 8'd0, 8'd63, 1'b1);
    send_word(8'd255, 8'd255, 8'd255, 1'b1);
    send_word(8'd20, 8'd64, 8'd70, 1'b1);
    send_word(8'd20, 8'd255, 8'd255, 1'b1);
    send_word(8'd20, 8'd70, 8'd64, 1'b1);
    send_word(8'd21, 8'd0, 8'd255, 1'b1);
    send_word(8'd21, 8'd200, 8'd30, 1'b0);
    send_word(8'd127, 8'd7, 8'd8, 1'b1);
    send_word(8'd127, 8'd8, 8'd15, 1'b0);
    send_word(8'd0, 8'd255, 8'd0, 1'b0);
    send_word(8'd64, 8'd56, 8'd63, 1'b1);
    send_word(8'd65, 8'd0, 8'd7, 1'b1);
  endtask

  // Mostly a few hot columns so spans land on bytes already drawn.
  task automatic test_random_spans(input int count);
    logic [7:0] hot [4];
    logic [7:0] col, r_a, r_b;
    for (int i = 0; i < 4; i++) hot[2'(i)] = 8'($urandom_range(0, psw_pkg::SCREEN_COLUMNS - 1));
    repeat (count) begin
      case ($urandom_range(0, 9))
        0:       col = 8'($urandom_range(0, 255));
        1, 2:    col = 8'($urandom_range(0, psw_pkg::SCREEN_COLUMNS - 1));
        default: col = hot[2'($urandom_range(0, 3))];
      endcase
      r_a = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, psw_pkg::SCREEN_ROWS - 1));
      r_b = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, psw_pkg::SCREEN_ROWS - 1));
      send_word(col, r_a, r_b, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_full_rate();
    calm = 1'b1;
    test_random_spans(40);
    calm = 1'b0;
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      test_random_spans(10);
      wait_drained();
    end
  endtask

  always @(posedge clk_i) begin : write_monitor
    page_write_t got, want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got = {half_sel_o, page_index_o, column_in_half_o, byte_value_o, last_write_o};
      if (pending_writes.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected word: half %0d page %0d col %0d byte %02h last %0d",
                   got.half, got.page, got.col, got.value, got.last);
      end else begin
        want = pending_writes.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: exp %0d/%0d/%0d/%02h/%0d got %0d/%0d/%0d/%02h/%0d",
                     want.half, want.page, want.col, want.value, want.last,
                     got.half, got.page, got.col, got.value, got.last);
        end
      end
      stall_left = calm ? 0 : $urandom_range(0, MAX_WAIT);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left > 0);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_spans(180);
    test_full_rate();
    test_drain_pause();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0 && pending_writes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
